/* rtl/rkfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfc_pkg
// Types, constants and the keystream table for the remote keystream frame
// cipher.
// ----------------------------------------------------------------------------
package rkfc_pkg;

   localparam int SEED_W     = 7;
   localparam int SEED_COUNT = 1 << SEED_W;
   localparam int KS_LEN     = 51;
   localparam int KEY_W      = 60;

   localparam logic [7:0] BYTE0_XOR = 8'h05;

   localparam logic [3:0] BTN_CODE_1 = 4'h0;
   localparam logic [3:0] BTN_CODE_2 = 4'h2;
   localparam logic [3:0] BTN_CODE_3 = 4'h4;
   localparam logic [3:0] BTN_CODE_4 = 4'h6;

   localparam logic [2:0] BTN_NUM_NONE = 3'd0;
   localparam logic [2:0] BTN_NUM_1    = 3'd1;
   localparam logic [2:0] BTN_NUM_2    = 3'd2;
   localparam logic [2:0] BTN_NUM_3    = 3'd3;
   localparam logic [2:0] BTN_NUM_4    = 3'd4;

   localparam logic CMD_DECRYPT = 1'b0;
   localparam logic CMD_ENCRYPT = 1'b1;

   typedef logic [KS_LEN-1:0] ks_row_type;
   typedef logic [SEED_COUNT-1:0][KS_LEN-1:0] ks_table_type;

   typedef struct packed {
      logic              command;
      logic [KEY_W-1:0]  key_in;
      logic [7:0]        hold_counter;
      logic [15:0]       parcel_counter;
      logic [31:0]       serial_number;
      logic [3:0]        button_code;
   } req_word_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_out;
      logic [6:0]        hold_counter_out;
      logic [15:0]       parcel_counter_out;
      logic [31:0]       serial_out;
      logic [3:0]        button_code_out;
      logic [2:0]        button_number;
   } rsp_word_type;

   // Row bit KS_LEN-1-k is step k; it lands on frame bit 55-k.
   function automatic ks_table_type build_ks_table();
      ks_table_type tbl;
      logic [7:0]   t;
      for (int s = 0; s < SEED_COUNT; s++) begin
         t = 8'(s);
         for (int k = 0; k < KS_LEN; k++) begin
            t = {t[6:0], t[3] ^ t[4]};
            tbl[s][KS_LEN-1-k] = t[7];
         end
      end
      return tbl;
   endfunction

   localparam ks_table_type KS_TABLE = build_ks_table();

endpackage

/* rtl/rkfc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkfc_core
// Combinational frame cipher: builds the frame, looks up the keystream for
// the seed and produces the encrypted key or the decrypted fields.
// ----------------------------------------------------------------------------
module rkfc_core
   import rkfc_pkg::*;
(
   input  req_word_type req,
   output rsp_word_type rsp
);

   logic [63:0]       frame_raw;
   logic [63:0]       frame_ks;
   logic [7:0]        byte0;
   logic [SEED_W-1:0] seed;
   ks_row_type        ks;
   logic [3:0]        btn;

   always_comb begin
      if (req.command == CMD_ENCRYPT) begin
         frame_raw = {req.hold_counter, req.parcel_counter, req.serial_number,
                      req.button_code, 4'h0};
         byte0     = {1'b0, req.hold_counter[6:0] ^ BYTE0_XOR[6:0]};
         seed      = SEED_W'(-req.hold_counter);
      end else begin
         frame_raw = {~req.key_in, 4'h0};
         byte0     = {1'b0, frame_raw[62:56] ^ BYTE0_XOR[6:0]};
         seed      = SEED_W'(-byte0);
      end
   end

   assign ks       = KS_TABLE[seed];
   assign frame_ks = {byte0, frame_raw[55:5] ^ ks, frame_raw[4:0]};
   assign btn      = frame_ks[7:4];

   always_comb begin
      rsp = '0;
      if (req.command == CMD_ENCRYPT) begin
         rsp.key_out = ~frame_ks[63:4];
      end else begin
         rsp.hold_counter_out   = frame_ks[62:56];
         rsp.parcel_counter_out = frame_ks[55:40];
         rsp.serial_out         = frame_ks[39:8];
         rsp.button_code_out    = btn;
         unique case (btn)
            BTN_CODE_1: rsp.button_number = BTN_NUM_1;
            BTN_CODE_2: rsp.button_number = BTN_NUM_2;
            BTN_CODE_3: rsp.button_number = BTN_NUM_3;
            BTN_CODE_4: rsp.button_number = BTN_NUM_4;
            default:    rsp.button_number = BTN_NUM_NONE;
         endcase
      end
   end

endmodule

/* rtl/remote_keystream_frame_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_keystream_frame_cipher
// Stateless 64-bit remote-control frame cipher, one word per cycle.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   start / busy        req_command, req_key_in, req_hold_counter,
//                                req_parcel_counter, req_serial_number,
//                                req_button_code
//  response  rsp_valid (strobe)  rsp_key_out, rsp_hold_counter_out,
//                                rsp_parcel_counter_out, rsp_serial_out,
//                                rsp_button_code_out, rsp_button_number
//
//  A word is taken in every cycle; its response strobes after passing the input
//  register, cipher logic with a 128-entry keystream table and the result
//  register. busy is high only during reset. Synchronous reset clears the
//  valid flags; words in flight are dropped. The receiver cannot stall.
// ----------------------------------------------------------------------------
module remote_keystream_frame_cipher
   import rkfc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [KEY_W-1:0]    req_key_in,
   input  logic [7:0]          req_hold_counter,
   input  logic [15:0]         req_parcel_counter,
   input  logic [31:0]         req_serial_number,
   input  logic [3:0]          req_button_code,
   output logic                rsp_valid,
   output logic [KEY_W-1:0]    rsp_key_out,
   output logic [6:0]          rsp_hold_counter_out,
   output logic [15:0]         rsp_parcel_counter_out,
   output logic [31:0]         rsp_serial_out,
   output logic [3:0]          rsp_button_code_out,
   output logic [2:0]          rsp_button_number
);

   req_word_type req_in;
   req_word_type req_ff;
   logic         req_valid_ff;
   rsp_word_type rsp_in;
   rsp_word_type rsp_ff;
   logic         rsp_valid_ff;
   logic         accept;

   assign busy   = reset;
   assign accept = start && !busy;

   assign req_in = '{command:        req_command,
                     key_in:         req_key_in,
                     hold_counter:   req_hold_counter,
                     parcel_counter: req_parcel_counter,
                     serial_number:  req_serial_number,
                     button_code:    req_button_code};

   rkfc_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
      if (accept) begin
         req_ff <= req_in;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_key_out            = rsp_ff.key_out;
   assign rsp_hold_counter_out   = rsp_ff.hold_counter_out;
   assign rsp_parcel_counter_out = rsp_ff.parcel_counter_out;
   assign rsp_serial_out         = rsp_ff.serial_out;
   assign rsp_button_code_out    = rsp_ff.button_code_out;
   assign rsp_button_number      = rsp_ff.button_number;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted word produced no response");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_valid_ff))
      else $error("response without a word in flight");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_key_out != '0) |->
         rsp_hold_counter_out == '0 && rsp_parcel_counter_out == '0 &&
         rsp_serial_out == '0 && rsp_button_number == BTN_NUM_NONE)
      else $error("encrypt response carries decrypted fields");

   a_btn_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_button_number != BTN_NUM_NONE) |->
         rsp_button_code_out == BTN_CODE_1 || rsp_button_code_out == BTN_CODE_2 ||
         rsp_button_code_out == BTN_CODE_3 || rsp_button_code_out == BTN_CODE_4)
      else $error("button number given for an unmapped code");

endmodule
